FILE: rtl/bthg_pkg.sv
// shared types, register map and reset values for the button tap/hold gesture block
`timescale 1ns / 1ps

package bthg_pkg;

  // timestamp and register widths
  localparam int unsigned TimeW = 63;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned ApbAw = 4;

  // register reset values
  localparam logic [CfgW-1:0] TapWindowRst = 32'd400000;
  localparam logic [CfgW-1:0] TapMaxRst    = 32'd250000;
  localparam logic [CfgW-1:0] HoldShortRst = 32'd1000000;
  localparam logic [CfgW-1:0] HoldLongRst  = 32'd5000000;

  // register index, taken from paddr word bits
  typedef enum logic [1:0] {
    REG_TAP_WINDOW = 2'd0,
    REG_TAP_MAX    = 2'd1,
    REG_HOLD_SHORT = 2'd2,
    REG_HOLD_LONG  = 2'd3
  } reg_idx_e;

  // reported gesture
  typedef enum logic [1:0] {
    GEST_NONE       = 2'd0,
    GEST_TRIPLE     = 2'd1,
    GEST_HOLD_SHORT = 2'd2,
    GEST_HOLD_LONG  = 2'd3
  } gesture_e;

  // thresholds handed from the register file to the detector
  typedef struct packed {
    logic [CfgW-1:0] tap_window_us;
    logic [CfgW-1:0] tap_max_us;
    logic [CfgW-1:0] hold_short_us;
    logic [CfgW-1:0] hold_long_us;
  } cfg_t;

endpackage

FILE: rtl/bthg_apb_regs.sv
// apb register file holding the four timing thresholds
`timescale 1ns / 1ps

module bthg_apb_regs import bthg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAw-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_window_us <= TapWindowRst;
      cfg_q.tap_max_us    <= TapMaxRst;
      cfg_q.hold_short_us <= HoldShortRst;
      cfg_q.hold_long_us  <= HoldLongRst;
    end else if (wr_en) begin
      case (idx)
        REG_TAP_WINDOW: cfg_q.tap_window_us <= pwdata;
        REG_TAP_MAX:    cfg_q.tap_max_us    <= pwdata;
        REG_HOLD_SHORT: cfg_q.hold_short_us <= pwdata;
        REG_HOLD_LONG:  cfg_q.hold_long_us  <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_TAP_WINDOW: prdata = cfg_q.tap_window_us;
      REG_TAP_MAX:    prdata = cfg_q.tap_max_us;
      REG_HOLD_SHORT: prdata = cfg_q.hold_short_us;
      REG_HOLD_LONG:  prdata = cfg_q.hold_long_us;
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bthg_fsm.sv
// press/tap/hold phase machine with its timestamps and the registered gesture code
`timescale 1ns / 1ps

module bthg_fsm import bthg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             level_i,
  input  logic [TimeW-1:0] time_i,
  input  cfg_t             cfg_i,
  output logic [1:0]       gesture_code_o
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_PRESSED    = 3'd1,
    PH_COUNTING   = 3'd2,
    PH_HOLD_SHORT = 3'd3,
    PH_HOLD_LONG  = 3'd4
  } phase_e;

  phase_e           phase_q, phase_d, phase_eff;
  logic [TimeW-1:0] press_q, press_d;
  logic [TimeW-1:0] tap_q, tap_d;
  logic [1:0]       taps_q, taps_d, taps_eff, taps_inc;
  gesture_e         code_q, code_d;

  logic             pressed;
  logic [TimeW:0]   d_press, d_tap;
  logic             win_expired, is_tap, past_short, past_long;

  assign pressed = !level_i;

  // signed differences; both operands stay below 2^63, so bit 63 is the sign
  assign d_press = {1'b0, time_i} - {1'b0, press_q};
  assign d_tap   = {1'b0, time_i} - {1'b0, tap_q};

  // threshold compares on the differences
  assign win_expired = !d_tap[TimeW] &&
                       ((|d_tap[TimeW-1:CfgW]) || (d_tap[CfgW-1:0] >= cfg_i.tap_window_us));
  assign is_tap      = d_press[TimeW] ||
                       (!(|d_press[TimeW-1:CfgW]) && (d_press[CfgW-1:0] <= cfg_i.tap_max_us));
  assign past_short  = !d_press[TimeW] &&
                       ((|d_press[TimeW-1:CfgW]) || (d_press[CfgW-1:0] >= cfg_i.hold_short_us));
  assign past_long   = !d_press[TimeW] &&
                       ((|d_press[TimeW-1:CfgW]) || (d_press[CfgW-1:0] >= cfg_i.hold_long_us));

  assign taps_inc = taps_eff + 2'd1;

  // next phase and gesture for one sample
  always_comb begin
    phase_eff = phase_q;
    taps_eff  = taps_q;
    if (phase_q == PH_COUNTING && win_expired) begin
      phase_eff = PH_IDLE;
      taps_eff  = 2'd0;
    end
    phase_d = phase_eff;
    taps_d  = taps_eff;
    press_d = press_q;
    tap_d   = tap_q;
    code_d  = GEST_NONE;
    case (phase_eff)
      PH_IDLE, PH_COUNTING: begin
        if (pressed) begin
          phase_d = PH_PRESSED;
          press_d = time_i;
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          if (is_tap) begin
            tap_d = time_i;
            if (taps_inc == 2'd3) begin
              phase_d = PH_IDLE;
              taps_d  = 2'd0;
              code_d  = GEST_TRIPLE;
            end else begin
              phase_d = PH_COUNTING;
              taps_d  = taps_inc;
            end
          end else begin
            phase_d = PH_IDLE;
            taps_d  = 2'd0;
          end
        end else if (past_short) begin
          phase_d = PH_HOLD_SHORT;
        end
      end
      // a hold release keeps the tap count
      PH_HOLD_SHORT: begin
        if (!pressed) begin
          phase_d = PH_IDLE;
          code_d  = GEST_HOLD_SHORT;
        end else if (past_long) begin
          phase_d = PH_HOLD_LONG;
        end
      end
      PH_HOLD_LONG: begin
        if (!pressed) begin
          phase_d = PH_IDLE;
          code_d  = GEST_HOLD_LONG;
        end
      end
      default: ;
    endcase
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      press_q <= '0;
      tap_q   <= '0;
      taps_q  <= 2'd0;
      code_q  <= GEST_NONE;
    end else if (step_i) begin
      phase_q <= phase_d;
      press_q <= press_d;
      tap_q   <= tap_d;
      taps_q  <= taps_d;
      code_q  <= code_d;
    end
  end

  assign gesture_code_o = code_q;

endmodule

FILE: rtl/button_tap_hold_gesture_core.sv
// top level: input register, gesture detector, result register and apb registers
`timescale 1ns / 1ps

//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, button_level_i,   | sink
//          | time_us_i                                 |
//  out     | out_valid_o, out_stall_i, gesture_code_o  | source
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | apb slave
//          | prdata, pready                            |
//
// one item per cycle unless stalled; an item passes the input, then the result register
// the detector state updates in the cycle an item moves from the input to the result register
// rst_ni clears phase, timestamps, tap count and all valid flags, thresholds go to defaults
// a stalled result holds the input register; in_stall_o rises only while both are full

module button_tap_hold_gesture_core import bthg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             button_level_i,
  input  logic [TimeW-1:0] time_us_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       gesture_code_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAw-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready
);

  cfg_t             cfg;
  logic             s1_valid_q;
  logic             s1_level_q;
  logic [TimeW-1:0] s1_time_q;
  logic             out_valid_q;
  logic             out_free, step, in_fire;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign step       = s1_valid_q && out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_level_q <= button_level_i;
      s1_time_q  <= time_us_i;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  bthg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bthg_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .level_i        (s1_level_q),
    .time_i         (s1_time_q),
    .cfg_i          (cfg),
    .gesture_code_o (gesture_code_o)
  );

  // an item that leaves the input register shows up as a result next cycle
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("item left input register without a result");

  // a taken result with nothing behind it empties the output
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after being taken");

  // input never stalls while the output side can take an item
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output drains");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// testbench for the button tap/hold gesture core: gesture scoreboard, item and apb drivers

module tb_top;
  import bthg_pkg::*;

  // detector phases as the scoreboard tracks them
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_COUNTING,
    PH_HOLD_SHORT,
    PH_HOLD_LONG
  } tap_phase_e;

  // kinds of threshold sets loaded between random phases
  typedef enum int {
    CFG_SMALL,
    CFG_ZERO,
    CFG_ONES,
    CFG_MIXED
  } cfg_kind_e;

  localparam logic             BtnDown       = 1'b0;
  localparam logic             BtnUp         = 1'b1;
  localparam int unsigned      TapsForTriple = 3;
  localparam int unsigned      MaxReported   = 10;
  localparam int unsigned      PhaseItems    = 100;
  localparam logic [TimeW-1:0] TimeMax       = {TimeW{1'b1}};

  // tracks detector state and holds the gestures still to come out
  class gesture_scoreboard;
    cfg_t        thr;
    tap_phase_e  phase;
    logic [63:0] press_t;
    logic [63:0] tap_t;
    logic [1:0]  taps;
    gesture_e    pending_q[$];
    int unsigned n_samples;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_seen[4];

    function new();
      thr.tap_window_us = TapWindowRst;
      thr.tap_max_us    = TapMaxRst;
      thr.hold_short_us = HoldShortRst;
      thr.hold_long_us  = HoldLongRst;
      phase     = PH_IDLE;
      press_t   = '0;
      tap_t     = '0;
      taps      = '0;
      n_samples = 0;
      n_checked = 0;
      n_errors  = 0;
      foreach (n_seen[i]) n_seen[i] = 0;
    endfunction

    function void set_threshold(reg_idx_e idx, logic [CfgW-1:0] v);
      case (idx)
        REG_TAP_WINDOW: thr.tap_window_us = v;
        REG_TAP_MAX:    thr.tap_max_us    = v;
        REG_HOLD_SHORT: thr.hold_short_us = v;
        REG_HOLD_LONG:  thr.hold_long_us  = v;
        default: ;
      endcase
    endfunction

    // signed wrapping difference at or past a threshold; negative never is
    function bit reached(logic [63:0] now, logic [63:0] past, logic [CfgW-1:0] th);
      logic [63:0] d;
      d = now - past;
      return !d[63] && (d >= 64'(th));
    endfunction

    // signed wrapping difference at most a threshold; negative always is
    function bit short_enough(logic [63:0] now, logic [63:0] past, logic [CfgW-1:0] th);
      logic [63:0] d;
      d = now - past;
      return d[63] || (d <= 64'(th));
    endfunction

    function void report(string msg);
      n_errors++;
      if (n_errors <= MaxReported) $display("%0t: %s", $realtime, msg);
    endfunction

    // advance the detector by one accepted item and queue its gesture
    function void note_sample(logic level, logic [TimeW-1:0] t);
      logic [63:0] now;
      gesture_e    code;
      now  = {1'b0, t};
      code = GEST_NONE;
      n_samples++;

      // tap window expiry ends counting
      if (phase == PH_COUNTING && reached(now, tap_t, thr.tap_window_us)) begin
        phase = PH_IDLE;
        taps  = '0;
      end

      case (phase)
        PH_IDLE, PH_COUNTING: begin
          if (level == BtnDown) begin
            phase   = PH_PRESSED;
            press_t = now;
          end
        end
        PH_PRESSED: begin
          if (level == BtnUp) begin
            if (short_enough(now, press_t, thr.tap_max_us)) begin
              taps  = taps + 2'd1;
              tap_t = now;
              if (taps >= TapsForTriple) begin
                phase = PH_IDLE;
                taps  = '0;
                code  = GEST_TRIPLE;
              end else begin
                phase = PH_COUNTING;
              end
            end else begin
              // too long for a tap, released before any hold was reached
              phase = PH_IDLE;
              taps  = '0;
            end
          end else if (reached(now, press_t, thr.hold_short_us)) begin
            phase = PH_HOLD_SHORT;
          end
        end
        PH_HOLD_SHORT: begin
          if (level == BtnUp) begin
            phase = PH_IDLE;
            code  = GEST_HOLD_SHORT;
          end else if (reached(now, press_t, thr.hold_long_us)) begin
            phase = PH_HOLD_LONG;
          end
        end
        PH_HOLD_LONG: begin
          if (level == BtnUp) begin
            phase = PH_IDLE;
            code  = GEST_HOLD_LONG;
          end
        end
        default: ;
      endcase
      pending_q.push_back(code);
    endfunction

    // compare one result item with the oldest pending gesture
    function void check_gesture(logic [1:0] got);
      gesture_e want;
      if (pending_q.size() == 0) begin
        report($sformatf("gesture %0d arrived with nothing pending", got));
      end else begin
        want = pending_q.pop_front();
        n_checked++;
        n_seen[want]++;
        if (got !== want)
          report($sformatf("gesture_code mismatch: expected %0d, got %0d", want, got));
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             button_level_i;
  logic [TimeW-1:0] time_us_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [1:0]       gesture_code_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAw-1:0] paddr;
  logic [CfgW-1:0]  pwdata;
  logic [CfgW-1:0]  prdata;
  logic             pready;

  gesture_scoreboard sb = new();
  int unsigned       send_idle_pct = 0;
  int unsigned       rcv_idle_pct  = 0;
  logic [TimeW-1:0]  cur_t = '0;

  button_tap_hold_gesture_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .time_us_i      (time_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gesture_code_o (gesture_code_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk_i = ~clk_i;

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_gesture(gesture_code_o);
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // one item, with random idle cycles in front; called and returns at a falling edge
  task automatic send_sample(logic level, logic [TimeW-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_level_i <= level;
    time_us_i      <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(level, t);
    @(negedge clk_i);
  endtask

  // apb write: setup, access, then back to idle
  task automatic apb_write(reg_idx_e idx, logic [CfgW-1:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ApbAw'({idx, 2'b00});
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_threshold(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait until every pending gesture has come out, then idle while the input and result registers empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [CfgW-1:0] extreme_or_small();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return CfgW'($urandom_range(0, 100));
    endcase
  endfunction

  task automatic load_thresholds(cfg_kind_e kind);
    logic [CfgW-1:0] w, m, s, l;
    case (kind)
      CFG_ZERO: begin
        w = '0; m = '0; s = '0; l = '0;
      end
      CFG_ONES: begin
        w = '1; m = '1; s = '1; l = '1;
      end
      CFG_MIXED: begin
        w = extreme_or_small();
        m = extreme_or_small();
        s = extreme_or_small();
        l = extreme_or_small();
      end
      default: begin
        w = $urandom_range(1, 200);
        m = $urandom_range(1, 40);
        s = m + $urandom_range(1, 100);
        l = s + $urandom_range(1, 200);
      end
    endcase
    apb_write(REG_TAP_WINDOW, w);
    apb_write(REG_TAP_MAX, m);
    apb_write(REG_HOLD_SHORT, s);
    apb_write(REG_HOLD_LONG, l);
  endtask

  // a step just under, at, just over or anywhere up to a threshold
  function automatic logic [63:0] near(logic [CfgW-1:0] th);
    case ($urandom_range(0, 3))
      0:       return (th == 0) ? 64'd0 : 64'(th) - 64'd1;
      1:       return 64'(th);
      2:       return 64'(th) + 64'd1;
      default: return 64'($urandom_range(0, th));
    endcase
  endfunction

  task automatic step(logic [63:0] d);
    cur_t = cur_t + d[TimeW-1:0];
  endtask

  // press and release within or near the tap limit, then a gap near the tap window or up to half of it
  task automatic tap_gesture();
    send_sample(BtnDown, cur_t);
    if ($urandom_range(0, 4) == 0) step(near(sb.thr.tap_max_us));
    else step(64'($urandom_range(0, sb.thr.tap_max_us)));
    send_sample(BtnUp, cur_t);
    if ($urandom_range(0, 1) == 0) step(near(sb.thr.tap_window_us));
    else step(64'($urandom_range(0, sb.thr.tap_window_us / 2)));
  endtask

  // press held around the short and maybe the long threshold
  task automatic hold_gesture();
    send_sample(BtnDown, cur_t);
    step(near(sb.thr.hold_short_us));
    send_sample(BtnDown, cur_t);
    if ($urandom_range(0, 1) == 0) begin
      step(near(sb.thr.hold_long_us));
      send_sample(BtnDown, cur_t);
    end
    step(64'($urandom_range(0, 20)));
    send_sample(BtnUp, cur_t);
  endtask

  // release just past the tap limit
  task automatic medium_press();
    send_sample(BtnDown, cur_t);
    step(64'(sb.thr.tap_max_us) + 64'd1 + 64'($urandom_range(0, 20)));
    send_sample(BtnUp, cur_t);
  endtask

  // random level with a small, backward, wild or no time step
  task automatic noise_sample();
    case ($urandom_range(0, 3))
      0:       step(64'($urandom_range(0, 50)));
      1:       cur_t = cur_t - TimeW'($urandom_range(1, 100));
      2:       cur_t = TimeW'({$urandom, $urandom});
      default: ;
    endcase
    send_sample(logic'($urandom_range(0, 1)), cur_t);
  endtask

  initial begin
    logic             dir_level[25];
    logic [TimeW-1:0] dir_time[25];
    cfg_kind_e        plan[6];
    int unsigned      target;
    int unsigned      pick;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    button_level_i = BtnUp;
    time_us_i      = '0;
    out_stall_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;

    // directed items under reset thresholds: triple tap, both holds, count kept
    // across a hold, press too long for a tap, backward time, window expiry
    dir_level = '{BtnUp, BtnDown, BtnUp, BtnDown, BtnUp, BtnDown, BtnUp, BtnDown,
                  BtnDown, BtnUp, BtnDown, BtnUp, BtnDown, BtnDown, BtnDown, BtnUp,
                  BtnDown, BtnUp, BtnDown, BtnUp, BtnDown, BtnUp, BtnDown, BtnUp,
                  BtnUp};
    dir_time  = '{0, 0, 100000, 200000, 300000, 350000, 400000, 1000000,
                  2100000, 2200000, 3000000, 3100000, 3200000, 4300000, 8300000,
                  8300001, 8400000, 8400010, 8400020, 8400030, 9000000, 9500000,
                  TimeMax, 0, TimeMax};
    plan = '{CFG_SMALL, CFG_ZERO, CFG_ONES, CFG_SMALL, CFG_MIXED, CFG_SMALL};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_level[i]) send_sample(dir_level[i], dir_time[i]);
    wait_drained();

    // random phases, each under a fresh threshold set
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0:       begin send_idle_pct = 11; rcv_idle_pct = 62; end
        1:       begin send_idle_pct = 62; rcv_idle_pct = 11; end
        default: begin send_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      load_thresholds(plan[p]);
      cur_t  = TimeW'({$urandom, $urandom});
      target = sb.n_samples + PhaseItems;
      while (sb.n_samples < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) tap_gesture();
        else if (pick < 15) hold_gesture();
        else if (pick < 17) medium_press();
        else noise_sample();
      end
      wait_drained();
    end

    $display("%0d items sent, %0d gestures checked: %0d triple taps, %0d short holds, %0d long holds",
             sb.n_samples, sb.n_checked, sb.n_seen[GEST_TRIPLE],
             sb.n_seen[GEST_HOLD_SHORT], sb.n_seen[GEST_HOLD_LONG]);
    $display("threshold sets: reset, small, all-zero, all-ones, mixed; %0d mismatches, %0d left over",
             sb.n_errors, sb.pending_q.size());
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bthg_pkg.sv
rtl/bthg_apb_regs.sv
rtl/bthg_fsm.sv
rtl/button_tap_hold_gesture_core.sv
test/tb_top.sv
